@@ rtl/core/rlrc_pkg.sv @@
`default_nettype none
package rlrc_pkg;
  localparam int RingDepth = 16;
  localparam int SlotW = $clog2(RingDepth);
  localparam int CountW = $clog2(RingDepth + 1);

  typedef enum logic [2:0] {
    OP_LOCAL = 3'd0,
    OP_RECV = 3'd1,
    OP_TICK = 3'd2,
    OP_RECONN = 3'd3,
    OP_DOWN = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    K_NONE = 4'd0,
    K_SEND = 4'd1,
    K_DELIVER = 4'd2,
    K_DISCARD = 4'd3,
    K_KEEPALIVE = 4'd4,
    K_FAIL = 4'd5,
    K_CLOSED = 4'd6,
    K_TOOBIG = 4'd7,
    K_FULL = 4'd8,
    K_MISMATCH = 4'd9
  } kind_t;

  localparam logic [1:0] CFG_MAX_LENGTH = 2'd0;
  localparam logic [1:0] CFG_SYNC_TICKS = 2'd1;
  localparam logic [1:0] CFG_MAX_MISSED = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RELEASE,
    ST_REPLAY,
    ST_EMIT,
    ST_FAIL
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input item
    logic exec;       // apply a single-step operation, build its result
    logic rel_step;   // release the oldest ring entry
    logic rel_done;   // build deliver or mismatch result
    logic rep_start;  // reset replay index
    logic rep_step;   // emit one replayed header
    logic fail_emit;  // emit failure result
    logic out_last;
  } cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic finished;
    logic connected;
    op_t op;
    logic is_data;     // received header will be delivered (in order)
    logic rel_more;    // another entry to release
    logic rel_bad;     // oldest entry number mismatch
    logic rep_more;    // entries remain to replay after the current one
    logic ring_empty;
    logic has_result;  // exec step produced a result
    logic tick_fail;   // keepalive tick pushes past the limit
    logic out_busy;    // output register holds an untaken result
  } stat_t;
endpackage
`default_nettype wire

@@ rtl/core/reliable_link_replay_control.sv @@
// Channel  | Direction | Transfer condition
// in_      | input     | in_valid && in_ready
// out_     | output    | out_valid && out_ready
// cfg_     | input     | cfg_valid && cfg_ready (always ready)
// An in-order header releases ring entries one at a time and then posts its result,
// a reconnect replays the ring entries one at a time and a failing tick posts a
// separate failure result; the ring's single read port sets that walk. Reset is
// synchronous and restores the register defaults with the link up and the ring
// empty. Results wait in an output register; a stalled output holds the controller
// before the next result.
`default_nettype none
module reliable_link_replay_control
  import rlrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_operation,
  input  wire logic [15:0] in_length,
  input  wire logic [31:0] in_msg_number,
  input  wire logic [31:0] in_acked_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_kind,
  output logic [15:0]      out_length,
  output logic [31:0]      out_msg,
  output logic [31:0]      out_acked,
  output logic [3:0]       out_slot,
  output logic [4:0]       out_released,
  output logic             out_last
);
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  rlrc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .stat, .cmd
  );

  rlrc_datapath u_dp (
    .clk, .rst_n, .cmd, .stat, .cfg_valid, .cfg_index, .cfg_data,
    .in_operation, .in_length, .in_msg_number, .in_acked_count,
    .out_valid, .out_ready, .out_kind, .out_length, .out_msg, .out_acked,
    .out_slot, .out_released, .out_last
  );
endmodule
`default_nettype wire

@@ rtl/core/rlrc_datapath.sv @@
`default_nettype none
module rlrc_datapath
  import rlrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic [2:0]  in_operation,
  input  wire logic [15:0] in_length,
  input  wire logic [31:0] in_msg_number,
  input  wire logic [31:0] in_acked_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_kind,
  output logic [15:0]      out_length,
  output logic [31:0]      out_msg,
  output logic [31:0]      out_acked,
  output logic [SlotW-1:0] out_slot,
  output logic [4:0]       out_released,
  output logic             out_last
);
  // Replay ring storage, one write and one read port.
  logic [31:0] ring_msg [RingDepth];
  logic [15:0] ring_len [RingDepth];
  logic [31:0] ring_ack [RingDepth];

  logic [15:0] max_length_r;
  logic [7:0]  sync_ticks_r;
  logic [2:0]  max_missed_r;
  logic [SlotW-1:0] head_r;
  logic [CountW-1:0] count_r;
  logic [31:0] recv_r, send_r, acked_r;
  logic [2:0]  missed_r;
  logic [7:0]  tick_r;
  logic        conn_r, fin_r;
  logic [2:0]  op_r;
  logic [15:0] len_r;
  logic [31:0] msg_r, ack_r;
  logic [4:0]  rel_r;
  logic [CountW-1:0] rep_i_r;
  logic [31:0] rd_msg_r, rd_ack_r;
  logic [15:0] rd_len_r;
  logic [SlotW-1:0] rd_slot_r;
  logic        ov_r;

  logic [SlotW-1:0] tail, rd_addr;
  logic [31:0] ack_diff;
  logic [7:0]  tick_inc;
  logic        wr_en;

  assign tail = head_r + count_r[SlotW-1:0];
  assign ack_diff = ack_r - acked_r;
  assign tick_inc = tick_r + 8'd1;
  assign wr_en = cmd.exec && op_r == OP_LOCAL && count_r != CountW'(RingDepth);

  // Read address follows the head during release and the replay index otherwise.
  // The replay index is cleared at load, so after a load the read addresses the head, and
  // a stalled replay keeps reading the entry that is still due.
  always_comb begin
    rd_addr = head_r + rep_i_r[SlotW-1:0];
    if (cmd.rep_start) rd_addr = head_r;
    else if (cmd.rep_step) rd_addr = head_r + rep_i_r[SlotW-1:0] + SlotW'(1);
    else if (cmd.rel_step) rd_addr = head_r + SlotW'(1);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_msg[tail] <= send_r;
      ring_len[tail] <= len_r;
      ring_ack[tail] <= recv_r;
    end
    rd_msg_r <= ring_msg[rd_addr];
    rd_len_r <= ring_len[rd_addr];
    rd_ack_r <= ring_ack[rd_addr];
    rd_slot_r <= rd_addr;
  end

  always_comb begin
    stat.finished = fin_r;
    stat.connected = conn_r;
    stat.op = op_t'(op_r);
    stat.is_data = len_r != 16'd0 && len_r <= max_length_r && msg_r == recv_r;
    stat.rel_more = count_r != '0 && ack_diff != 32'd0 && !ack_diff[31];
    stat.rel_bad = rd_msg_r != acked_r;
    stat.rep_more = rep_i_r + CountW'(1) < count_r;
    stat.ring_empty = count_r == '0;
    stat.tick_fail = 4'(missed_r) + 4'd1 > 4'(max_missed_r);
    stat.out_busy = ov_r && !out_ready;
    stat.has_result = 1'b0;
    case (op_r)
      OP_LOCAL: stat.has_result = 1'b1;
      OP_RECV: stat.has_result = conn_r && !(len_r == 16'd0 && msg_r == '1);
      OP_TICK: stat.has_result = conn_r && tick_inc >= sync_ticks_r;
      default: stat.has_result = 1'b0;
    endcase
  end

  assign out_valid = ov_r;

  // Configuration, control state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= 16'd8192;
      sync_ticks_r <= 8'd2;
      max_missed_r <= 3'd2;
      head_r <= '0;
      count_r <= '0;
      recv_r <= '0;
      send_r <= '0;
      acked_r <= '0;
      missed_r <= '0;
      tick_r <= '0;
      conn_r <= 1'b1;
      fin_r <= 1'b0;
      ov_r <= 1'b0;
      rel_r <= '0;
      rep_i_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MAX_LENGTH: max_length_r <= cfg_data;
          CFG_SYNC_TICKS: sync_ticks_r <= cfg_data[7:0];
          CFG_MAX_MISSED: max_missed_r <= cfg_data[2:0];
          default: ;
        endcase
      end
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (cmd.load) begin
        op_r <= in_operation;
        len_r <= in_length;
        msg_r <= in_msg_number;
        ack_r <= in_acked_count;
        rel_r <= '0;
        rep_i_r <= '0;
      end
      if (cmd.exec) begin
        out_last <= cmd.out_last;
        out_released <= '0;
        out_length <= '0;
        out_msg <= '0;
        out_acked <= '0;
        out_slot <= '0;
        out_kind <= K_NONE;
        case (op_r)
          OP_LOCAL: begin
            ov_r <= 1'b1;
            if (count_r == CountW'(RingDepth)) begin
              out_kind <= K_FULL;
            end else begin
              count_r <= count_r + CountW'(1);
              send_r <= send_r + 32'd1;
              out_slot <= tail;
              if (conn_r) begin
                out_kind <= K_SEND;
                out_length <= len_r;
                out_msg <= send_r;
                out_acked <= recv_r;
                if (len_r == 16'd0) fin_r <= 1'b1;
              end
            end
          end
          OP_RECV: if (conn_r) begin
            missed_r <= '0;
            if (len_r == 16'd0) begin
              if (msg_r != '1) begin
                fin_r <= 1'b1;
                out_kind <= K_CLOSED;
                ov_r <= 1'b1;
              end
            end else if (len_r > max_length_r) begin
              fin_r <= 1'b1;
              out_kind <= K_TOOBIG;
              out_length <= len_r;
              ov_r <= 1'b1;
            end else if (msg_r != recv_r) begin
              out_kind <= K_DISCARD;
              out_length <= len_r;
              out_msg <= msg_r;
              ov_r <= 1'b1;
            end else begin
              recv_r <= recv_r + 32'd1;
            end
          end
          OP_TICK: if (conn_r) begin
            tick_r <= tick_inc;
            if (tick_inc >= sync_ticks_r) begin
              tick_r <= '0;
              out_kind <= K_KEEPALIVE;
              out_msg <= '1;
              out_acked <= recv_r;
              ov_r <= 1'b1;
              if (stat.tick_fail) begin
                missed_r <= '0;
                conn_r <= 1'b0;
              end else begin
                missed_r <= missed_r + 3'd1;
              end
            end
          end
          OP_RECONN: begin
            conn_r <= 1'b1;
            tick_r <= '0;
            missed_r <= '0;
          end
          OP_DOWN: conn_r <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.rel_step) begin
        head_r <= head_r + SlotW'(1);
        count_r <= count_r - CountW'(1);
        acked_r <= acked_r + 32'd1;
        rel_r <= rel_r + 5'd1;
      end
      if (cmd.rel_done) begin
        ov_r <= 1'b1;
        out_last <= 1'b1;
        out_released <= rel_r;
        out_msg <= '0;
        out_acked <= '0;
        out_slot <= '0;
        if (cmd.out_last == 1'b0) begin
          fin_r <= 1'b1;
          out_kind <= K_MISMATCH;
          out_length <= '0;
        end else begin
          out_kind <= K_DELIVER;
          out_length <= len_r;
          out_msg <= msg_r;
        end
      end
      if (cmd.rep_start) rep_i_r <= '0;
      if (cmd.rep_step) begin
        rep_i_r <= rep_i_r + CountW'(1);
        ov_r <= 1'b1;
        out_kind <= K_SEND;
        out_length <= rd_len_r;
        out_msg <= rd_msg_r;
        out_acked <= rd_ack_r;
        out_slot <= rd_slot_r;
        out_released <= '0;
        out_last <= cmd.out_last;
      end
      if (cmd.fail_emit) begin
        ov_r <= 1'b1;
        out_kind <= K_FAIL;
        out_length <= '0;
        out_msg <= '0;
        out_acked <= '0;
        out_slot <= '0;
        out_released <= '0;
        out_last <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/rlrc_ctrl.sv @@
`default_nettype none
module rlrc_ctrl
  import rlrc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // The loaded item is resolved here once the output register is free; after a finish it is dropped.
        if (stat.finished) begin
          state_nxt = ST_IDLE;
        end else if (!stat.out_busy) begin
          if (stat.op == OP_RECV && stat.connected && stat.is_data) begin
            cmd.exec = 1'b1;
            state_nxt = ST_RELEASE;
          end else if (stat.op == OP_RECONN) begin
            cmd.exec = 1'b1;
            cmd.rep_start = 1'b1;
            state_nxt = stat.ring_empty ? ST_IDLE : ST_REPLAY;
          end else begin
            cmd.exec = 1'b1;
            cmd.out_last = !(stat.op == OP_TICK && stat.tick_fail);
            state_nxt = (stat.op == OP_TICK && stat.has_result && stat.tick_fail)
                        ? ST_FAIL : ST_IDLE;
          end
        end
      end
      ST_RELEASE: begin
        // One ring entry per cycle; the head entry was read last cycle.
        if (stat.rel_more && !stat.rel_bad) begin
          cmd.rel_step = 1'b1;
        end else if (!stat.out_busy) begin
          cmd.rel_done = 1'b1;
          cmd.out_last = !(stat.rel_more && stat.rel_bad);
          state_nxt = ST_IDLE;
        end
      end
      ST_REPLAY: begin
        if (!stat.out_busy) begin
          cmd.rep_step = 1'b1;
          cmd.out_last = !stat.rep_more;
          if (!stat.rep_more) state_nxt = ST_IDLE;
        end
      end
      ST_FAIL: begin
        if (!stat.out_busy) begin
          cmd.fail_emit = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire
